// ===== rtl/oaht_pkg.sv =====
// types, codes and constants shared by the open-addressing hash table
`timescale 1ns / 1ps
package oaht_pkg;

	localparam int TABLE_SLOTS = 128;
	localparam int KEY_BITS    = 32;
	localparam int SLOT_BITS   = $clog2(TABLE_SLOTS);

	// request kinds
	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_SEARCH = 2'd1;
	localparam logic [1:0] OP_ERASE  = 2'd2;

	// probe sequences
	localparam logic [1:0] MODE_LINEAR = 2'd0;
	localparam logic [1:0] MODE_QUAD   = 2'd1;
	localparam logic [1:0] MODE_DOUBLE = 2'd2;

	// per-slot marks
	localparam logic [1:0] MARK_EMPTY = 2'd0;
	localparam logic [1:0] MARK_USED  = 2'd1;
	localparam logic [1:0] MARK_GONE  = 2'd2;

	// quadratic probe: slot(i) = home + QUAD_LIN*i + QUAD_SQR*i*i
	// first difference starts at QUAD_LIN + QUAD_SQR, grows by 2*QUAD_SQR
	localparam int QUAD_LIN      = 214;
	localparam int QUAD_SQR      = 4412;
	localparam int QUAD_STEP0    = (QUAD_LIN + QUAD_SQR) % TABLE_SLOTS;
	localparam int QUAD_STEP_INC = (2 * QUAD_SQR) % TABLE_SLOTS;

	typedef logic [1:0] mode_t;

	typedef struct packed {
		logic [1:0]          op;
		logic [KEY_BITS-1:0] key;
	} req_t;

	typedef struct packed {
		logic       hit;
		logic [6:0] slot;
	} rsp_t;

	typedef struct packed {
		logic [1:0]          mark;
		logic [KEY_BITS-1:0] key;
	} entry_t;

	typedef enum logic [1:0] {
		ST_IDLE  = 2'b01,
		ST_PROBE = 2'b10
	} state_t;

endpackage

// ===== rtl/oaht_ram.sv =====
// generic single-port-write, single-port-read ram with registered read data
`timescale 1ns / 1ps
module oaht_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/open_addressing_hash_table_unit.sv =====
// open-addressing hash table: insert, search and erase of keys with a probe sequencer
//
//  channel | signals                         | direction | word
//  --------+---------------------------------+-----------+--------------------------
//  in      | in_valid, in_ready, in_data     | input     | op, key
//  out     | out_valid, out_ready, out_data  | output    | hit, slot
//  cfg     | cfg_valid, cfg_ready, cfg_data  | input     | probe_mode
//
// a request is accepted, then probes 1 .. 128 slots along its path;
// the slot ram gives one entry per cycle and the slot address adder walks the sequence.
// reset clears the per-slot valid flags, so every slot reads as empty; no clearing pass.
// in_ready is high only while no request is in the sequencer; a finished result
// waits in the output register and a new request is accepted meanwhile.
`timescale 1ns / 1ps
module open_addressing_hash_table_unit
	import oaht_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  req_t  in_data,
	output logic  out_valid,
	input  logic  out_ready,
	output rsp_t  out_data,
	input  logic  cfg_valid,
	output logic  cfg_ready,
	input  mode_t cfg_data
);

	state_t               state_q;
	mode_t                probe_mode_q;
	logic [1:0]           op_q;
	logic [KEY_BITS-1:0]  key_q;
	logic [SLOT_BITS-1:0] slot_q;
	logic [SLOT_BITS-1:0] stride_q;
	logic [SLOT_BITS-1:0] count_q;
	logic [TABLE_SLOTS-1:0] valid_q;
	logic                 out_valid_q;
	rsp_t                 out_data_q;

	logic [SLOT_BITS-1:0] home;
	logic [SLOT_BITS-1:0] stride_init;
	logic [SLOT_BITS-1:0] stride_inc;
	logic [SLOT_BITS-1:0] slot_next;
	logic [SLOT_BITS-1:0] raddr;
	logic [$bits(entry_t)-1:0] rdata;
	entry_t               entry;
	logic [1:0]           mark;
	logic                 used;
	logic                 match;
	logic                 done;
	logic                 hit;
	logic                 wr_needed;
	logic [1:0]           wr_mark;
	logic                 out_free;
	logic                 finish;
	logic                 advance;
	logic                 in_fire;
	entry_t               wentry;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign out_free  = !out_valid_q || out_ready;

	assign home = in_data.key[SLOT_BITS-1:0];

	always_comb begin
		unique case (probe_mode_q)
			MODE_QUAD: begin
				stride_init = SLOT_BITS'(QUAD_STEP0);
				stride_inc  = SLOT_BITS'(QUAD_STEP_INC);
			end
			MODE_DOUBLE: begin
				// step equals the home slot, zero for multiples of the table size
				stride_init = home;
				stride_inc  = '0;
			end
			default: begin
				stride_init = SLOT_BITS'(1);
				stride_inc  = '0;
			end
		endcase
	end

	// shared address step: table size is a power of two, so the sum wraps
	assign slot_next = slot_q + stride_q;

	assign entry = entry_t'(rdata);
	assign mark  = valid_q[slot_q] ? entry.mark : MARK_EMPTY;
	assign used  = (mark == MARK_USED);
	assign match = used && (entry.key == key_q);

	always_comb begin
		done      = 1'b0;
		hit       = 1'b0;
		wr_needed = 1'b0;
		wr_mark   = MARK_USED;
		unique case (op_q)
			OP_INSERT: begin
				if (!used) begin
					done      = 1'b1;
					hit       = 1'b1;
					wr_needed = 1'b1;
				end
			end
			OP_SEARCH, OP_ERASE: begin
				if (match) begin
					done      = 1'b1;
					hit       = 1'b1;
					wr_needed = (op_q == OP_ERASE);
					wr_mark   = MARK_GONE;
				end else if (mark == MARK_EMPTY) begin
					done = 1'b1;
				end
			end
			default: begin
				done = 1'b1;
			end
		endcase
		// whole probe path seen without an answer
		if (count_q == SLOT_BITS'(TABLE_SLOTS - 1)) begin
			done = 1'b1;
		end
	end

	assign finish  = (state_q == ST_PROBE) && done && out_free;
	assign advance = (state_q == ST_PROBE) && !done;

	always_comb begin
		if (state_q == ST_IDLE) begin
			raddr = home;
		end else if (advance) begin
			raddr = slot_next;
		end else begin
			raddr = slot_q;
		end
	end

	assign wentry.mark = wr_mark;
	assign wentry.key  = key_q;

	oaht_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(TABLE_SLOTS)
	) u_slots (
		.clk   (clk),
		.we    (finish && wr_needed),
		.waddr (slot_q),
		.wdata (wentry),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			probe_mode_q <= MODE_LINEAR;
			valid_q      <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				probe_mode_q <= cfg_data;
			end
			if (finish && wr_needed) begin
				valid_q[slot_q] <= 1'b1;
			end
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						state_q <= ST_PROBE;
					end
				end
				ST_PROBE: begin
					if (finish) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_q     <= in_data.op;
			key_q    <= in_data.key;
			slot_q   <= home;
			stride_q <= stride_init;
			count_q  <= '0;
		end else if (advance) begin
			slot_q   <= slot_next;
			stride_q <= stride_q + stride_inc;
			count_q  <= count_q + SLOT_BITS'(1);
		end
		if (finish) begin
			out_data_q.hit  <= hit;
			out_data_q.slot <= hit ? 7'(slot_q) : 7'd0;
		end
	end

endmodule

// ===== bench/tb.sv =====
// testbench for the open-addressing hash table unit: shadow table, random traffic, stalls
`timescale 1ns / 1ps
module tb;
	import oaht_pkg::*;

	// codes the package leaves unnamed
	localparam logic [1:0] OP_SPARE   = 2'd3;
	localparam mode_t      MODE_SPARE = 2'd3;

	logic  clk;
	logic  arst_n;
	logic  in_valid;
	logic  in_ready;
	req_t  in_data;
	logic  out_valid;
	logic  out_ready;
	rsp_t  out_data;
	logic  cfg_valid;
	logic  cfg_ready;
	mode_t cfg_data;

	open_addressing_hash_table_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	// shadow copy of the table and its probe mode
	logic [1:0]          shadow_mark [TABLE_SLOTS];
	logic [KEY_BITS-1:0] shadow_key  [TABLE_SLOTS];
	mode_t               shadow_mode;

	rsp_t rsp_due_q[$];
	int   mismatches;
	bit   idle_in;
	bit   idle_out;
	int   rx_hold_cycles;
	logic [KEY_BITS-1:0] key_pool [32];

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#(64'd10_000_000);
		$display("DONE: errors detected");
		$finish;
	end

	function automatic logic [SLOT_BITS-1:0] slot_on_path(logic [KEY_BITS-1:0] k, int i);
		longint unsigned home;
		longint unsigned ii;
		longint unsigned s;
		home = k % TABLE_SLOTS;
		ii = i;
		case (shadow_mode)
			MODE_QUAD:   s = home + QUAD_LIN * ii + QUAD_SQR * ii * ii;
			MODE_DOUBLE: s = home + ii * home;
			default:     s = home + ii;
		endcase
		return SLOT_BITS'(s % TABLE_SLOTS);
	endfunction

	// walks the probe path on the shadow table, updates it and returns the response
	function automatic rsp_t table_apply(req_t r);
		rsp_t res;
		logic [SLOT_BITS-1:0] s;
		bit done;
		res = '0;
		done = 1'b0;
		if (r.op == OP_INSERT || r.op == OP_SEARCH || r.op == OP_ERASE) begin
			for (int i = 0; i < TABLE_SLOTS && !done; i++) begin
				s = slot_on_path(r.key, i);
				if (r.op == OP_INSERT) begin
					if (shadow_mark[s] != MARK_USED) begin
						shadow_key[s] = r.key;
						shadow_mark[s] = MARK_USED;
						res.hit = 1'b1;
						res.slot = 7'(s);
						done = 1'b1;
					end
				end else if (shadow_mark[s] == MARK_USED && shadow_key[s] == r.key) begin
					if (r.op == OP_ERASE)
						shadow_mark[s] = MARK_GONE;
					res.hit = 1'b1;
					res.slot = 7'(s);
					done = 1'b1;
				end else if (shadow_mark[s] == MARK_EMPTY) begin
					done = 1'b1;
				end
			end
		end
		return res;
	endfunction

	// one request word, with a random gap before it when idling is on
	task automatic send_req(input logic [1:0] op, input logic [KEY_BITS-1:0] key);
		req_t r;
		int gap;
		r.op = op;
		r.key = key;
		gap = idle_in ? $urandom_range(0, 14) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_data <= r;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		rsp_due_q.push_back(table_apply(r));
	endtask

	task automatic wait_drained;
		in_valid <= 1'b0;
		do @(posedge clk); while (rsp_due_q.size() != 0);
	endtask

	task automatic set_probe_mode(input mode_t m);
		wait_drained();
		cfg_data <= m;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		shadow_mode = m;
	endtask

	// duplicates, erase marks, wrap at the top slot, misses, unused op
	task automatic test_linear_basics;
		set_probe_mode(MODE_LINEAR);
		send_req(OP_INSERT, 32'd0);
		send_req(OP_INSERT, 32'd0);
		send_req(OP_INSERT, 32'd128);
		send_req(OP_SEARCH, 32'd128);
		send_req(OP_ERASE, 32'd0);
		send_req(OP_SEARCH, 32'd0);
		send_req(OP_INSERT, 32'hFFFF_FFFF);
		send_req(OP_INSERT, 32'd127);
		send_req(OP_SEARCH, 32'hFFFF_FF80);
		send_req(OP_ERASE, 32'hDEAD_BEEF);
		send_req(OP_SPARE, 32'hFFFF_FFFF);
		send_req(OP_SEARCH, 32'd127);
	endtask

	task automatic test_unused_mode;
		set_probe_mode(MODE_SPARE);
		send_req(OP_INSERT, 32'd5);
		send_req(OP_SEARCH, 32'd5);
	endtask

	// zero step keeps hitting the home slot: full path on insert, long misses
	task automatic test_double_zero_step;
		set_probe_mode(MODE_DOUBLE);
		send_req(OP_INSERT, 32'd256);
		send_req(OP_SEARCH, 32'd384);
		send_req(OP_ERASE, 32'd0);
		send_req(OP_INSERT, 32'd3);
		send_req(OP_INSERT, 32'd3);
		send_req(OP_SEARCH, 32'd3);
	endtask

	task automatic test_quadratic;
		set_probe_mode(MODE_QUAD);
		send_req(OP_INSERT, 32'd1);
		send_req(OP_INSERT, 32'h5555_5555);
		send_req(OP_INSERT, 32'hAAAA_AAAA);
		send_req(OP_ERASE, 32'h5555_5555);
		send_req(OP_SEARCH, 32'hAAAA_AAAA);
	endtask

	function automatic logic [KEY_BITS-1:0] pick_key;
		if ($urandom_range(0, 99) < 65)
			return key_pool[$urandom_range(0, 31)];
		return $urandom;
	endfunction

	function automatic logic [1:0] pick_op;
		int r;
		r = $urandom_range(0, 99);
		if (r < 4)
			return OP_SPARE;
		if (r < 44)
			return OP_INSERT;
		if (r < 72)
			return OP_SEARCH;
		return OP_ERASE;
	endfunction

	// receiver holds off for a long stretch while words keep coming
	task automatic test_backpressure;
		set_probe_mode(MODE_LINEAR);
		idle_in = 1'b0;
		idle_out = 1'b0;
		rx_hold_cycles = 400;
		repeat (30) send_req(pick_op(), pick_key());
		wait_drained();
	endtask

	task automatic test_random_mix;
		mode_t modes [7];
		int counted;
		logic [1:0] op;
		modes = '{MODE_LINEAR, MODE_QUAD, MODE_DOUBLE, MODE_SPARE, MODE_DOUBLE,
			MODE_LINEAR, MODE_QUAD};
		for (int p = 0; p < 7; p++) begin
			set_probe_mode(modes[p]);
			idle_in = ($urandom_range(0, 3) != 0);
			idle_out = ($urandom_range(0, 3) != 0);
			counted = 0;
			while (counted < 128) begin
				op = pick_op();
				send_req(op, pick_key());
				if (op != OP_SPARE)
					counted++;
			end
		end
	endtask

	// receiver: random wait before each result word when idling is on, plus any requested hold-off
	initial begin
		int n;
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			n = idle_out ? $urandom_range(0, 14) : 0;
			n += rx_hold_cycles;
			rx_hold_cycles = 0;
			if (n > 0) begin
				out_ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (out_valid !== 1'b1);
		end
	end

	always @(posedge clk) begin
		rsp_t want;
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
			if (rsp_due_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result word: hit %0b slot %0d",
						out_data.hit, out_data.slot);
			end else begin
				want = rsp_due_q.pop_front();
				if (out_data.hit !== want.hit || out_data.slot !== want.slot) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected hit %0b slot %0d, got hit %0b slot %0d",
							want.hit, want.slot, out_data.hit, out_data.slot);
				end
			end
		end
	end

	initial begin
		mismatches = 0;
		idle_in = 1'b0;
		idle_out = 1'b0;
		rx_hold_cycles = 0;
		shadow_mode = MODE_LINEAR;
		for (int i = 0; i < TABLE_SLOTS; i++) begin
			shadow_mark[i] = MARK_EMPTY;
			shadow_key[i] = '0;
		end
		for (int i = 0; i < 32; i++) begin
			case (i % 4)
				0: key_pool[i] = $urandom;
				1: key_pool[i] = $urandom & 32'hFFFF_FF80;
				2: key_pool[i] = $urandom_range(0, 255);
				default: key_pool[i] = 32'hFFFF_FF00 | $urandom_range(0, 255);
			endcase
		end
		key_pool[0] = 32'd0;
		key_pool[1] = 32'hFFFF_FFFF;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_data <= '0;
		cfg_valid <= 1'b0;
		cfg_data <= MODE_LINEAR;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_linear_basics();
		test_unused_mode();
		test_double_zero_step();
		test_quadratic();
		test_backpressure();
		test_random_mix();

		wait_drained();
		repeat (20) @(posedge clk);
		if (mismatches == 0 && rsp_due_q.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
